// ----- sv/chp_pkg.sv -----
// Shared constants for the conservation-law halfspace projection core.
// No dependencies; imported by conservation_halfspace_projection_core.
`timescale 1ns / 1ps
`default_nettype none

package chp_pkg;

	localparam int MAX_SPECIES = 32;
	localparam int ADDR_W      = $clog2(MAX_SPECIES);
	localparam int CNT_W       = $clog2(MAX_SPECIES + 1);

	localparam int CONC_BITS   = 32;
	localparam int COEF_W      = 4;
	localparam int DEF_W       = 31;

	// dot accumulator and divider widths
	localparam int DOT_W       = 48;
	localparam int NORM_W      = 13;
	localparam int PP_W        = CONC_BITS + COEF_W + 1;
	localparam int DIV_W       = DOT_W;
	localparam int DIV_CNT_W   = $clog2(DIV_W);

	// deficit squaring: magnitudes at or above 2^SQ_IN_W always saturate
	localparam int SQ_IN_W     = 32;
	localparam int SQ_W        = 2 * SQ_IN_W;
	localparam int FRAC_SHIFT  = 16;

	// per-species correction
	localparam int PROD_W      = DIV_W + COEF_W;
	localparam int SUM_W       = PROD_W + 2;
	localparam int SMALL_W     = NORM_W + COEF_W;

	localparam int MEM_W       = COEF_W + CONC_BITS;

endpackage

`default_nettype wire

// ----- sv/conservation_halfspace_projection_core.sv -----
// Halfspace projection of a buffered species vector onto one conservation law.
// Depends on chp_pkg for widths and constants.
`timescale 1ns / 1ps
`default_nettype none

// Each request loads one species (dropped when the buffer is full); busy stays low between loads.
// The request marked last closes the run and busy rises until the final result
// has been issued. For a run that needs correction, one shared restoring divider
// (one quotient bit per cycle, 48 bits) runs twice, once for dot/norm and once
// for the deficit; a fulfilled run skips both divisions. Each species then needs
// a memory read, a multiply and a final add. When the dot magnitude is too large
// for the deficit to come out below saturation, the second division is skipped.
// Results are issued with a one-cycle strobe; the receiver cannot stall them, so
// sample on every strobe.
module conservation_halfspace_projection_core
	import chp_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [COEF_W-1:0]           coefficient,
	input  wire logic signed [CONC_BITS-1:0] concentration,
	input  wire logic                        last,
	output logic                             strobe,
	output logic signed [CONC_BITS-1:0]      projected_conc,
	output logic [DEF_W-1:0]                 deficit,
	output logic                             fulfilled,
	output logic                             end_of_run
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PREP  = 4'd1;
	localparam logic [3:0] S_DIVA  = 4'd2;
	localparam logic [3:0] S_SQ    = 4'd3;
	localparam logic [3:0] S_LOADB = 4'd4;
	localparam logic [3:0] S_DIVB  = 4'd5;
	localparam logic [3:0] S_DEF   = 4'd6;
	localparam logic [3:0] S_RD    = 4'd7;
	localparam logic [3:0] S_CALC  = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	function automatic logic [COEF_W-1:0] small_div(input logic [SMALL_W-1:0] x,
			input logic [NORM_W-1:0] d);
		logic [SMALL_W-1:0] r;
		logic [SMALL_W-1:0] ds;
		logic [COEF_W-1:0]  q;
		r = x;
		q = '0;
		for (int i = COEF_W - 1; i >= 0; i--) begin
			ds = SMALL_W'(d) << i;
			if (r >= ds) begin
				r    = r - ds;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	logic [3:0]               state_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [DOT_W-1:0]  dot_q;
	logic [NORM_W-1:0]        norm_q;
	logic [ADDR_W-1:0]        idx_q;
	logic                     ok_q;
	logic [DIV_W-1:0]         mag_q;
	logic [DIV_W-1:0]         quo_q;
	logic [NORM_W-1:0]        rem_q;
	logic [DIV_CNT_W-1:0]     div_cnt_q;
	logic [DIV_W-1:0]         qm_q;
	logic [NORM_W-1:0]        rm_q;
	logic [SQ_W-1:0]          sq_q;
	logic                     sat_q;
	logic [DEF_W-1:0]         def_q;
	logic [MEM_W-1:0]         mem [MAX_SPECIES];
	logic [MEM_W-1:0]         rd_q;
	logic [PROD_W-1:0]        prod_q;
	logic [COEF_W-1:0]        frac_q;
	logic                     strobe_q;
	logic signed [CONC_BITS-1:0] conc_out_q;
	logic [DEF_W-1:0]         deficit_q;
	logic                     fulfilled_q;
	logic                     eor_q;

	logic                     req;
	logic                     room;
	logic signed [COEF_W:0]   nu_s;
	logic signed [PP_W-1:0]   pp;
	logic [2*COEF_W-1:0]      nsq;
	logic [DIV_W-1:0]         mag_w;
	logic [NORM_W:0]          trial;
	logic                     ge;
	logic                     div_last;
	logic                     idx_last;
	logic [COEF_W-1:0]        rd_coef;
	logic signed [SUM_W-1:0]  sum;
	logic                     sum_sat;

	assign busy     = (state_q != S_IDLE);
	assign req      = start && !busy;
	assign room     = (count_q < CNT_W'(MAX_SPECIES));
	assign nu_s     = signed'({1'b0, coefficient});
	assign pp       = nu_s * concentration;
	assign nsq      = coefficient * coefficient;
	assign mag_w    = unsigned'(-dot_q);

	// one restoring divider step: bring in the next dividend bit, subtract if it fits
	assign trial    = {rem_q, quo_q[DIV_W-1]};
	assign ge       = (trial >= {1'b0, norm_q});
	assign div_last = (div_cnt_q == DIV_CNT_W'(DIV_W - 1));

	assign idx_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign rd_coef  = rd_q[MEM_W-1:CONC_BITS];

	assign sum = SUM_W'(signed'(rd_q[CONC_BITS-1:0]))
		+ signed'(SUM_W'(prod_q))
		+ signed'(SUM_W'(frac_q));
	// correction only ever raises the value, so only the upper bound can be crossed
	assign sum_sat = !sum[SUM_W-1] && (sum[SUM_W-2:CONC_BITS-1] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			dot_q     <= '0;
			norm_q    <= '0;
			idx_q     <= '0;
			ok_q      <= 1'b1;
			div_cnt_q <= '0;
			sat_q     <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= (state_q == S_OUT);
			case (state_q)
				S_IDLE: begin
					if (req) begin
						// drop the request when the buffer is full, but still honour last
						if (room) begin
							count_q <= count_q + CNT_W'(1);
							dot_q   <= dot_q + DOT_W'(pp);
							norm_q  <= norm_q + NORM_W'(nsq);
						end
						if (last) begin
							state_q <= S_PREP;
						end
					end
				end
				S_PREP: begin
					idx_q <= '0;
					ok_q  <= !(dot_q[DOT_W-1] && (norm_q != '0));
					if (count_q == '0) begin
						state_q <= S_IDLE;
					end else if (dot_q[DOT_W-1] && (norm_q != '0)) begin
						div_cnt_q <= '0;
						state_q   <= S_DIVA;
					end else begin
						state_q <= S_RD;
					end
				end
				S_DIVA: begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_last) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					sat_q   <= (mag_q[DIV_W-1:SQ_IN_W] != '0);
					state_q <= S_LOADB;
				end
				S_LOADB: begin
					div_cnt_q <= '0;
					state_q   <= sat_q ? S_RD : S_DIVB;
				end
				S_DIVB: begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_last) begin
						state_q <= S_DEF;
					end
				end
				S_DEF: begin
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_CALC;
				end
				S_CALC: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (idx_last) begin
						count_q <= '0;
						dot_q   <= '0;
						norm_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + ADDR_W'(1);
						state_q <= S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath: divider, squaring, correction terms
	always_ff @(posedge clk) begin
		case (state_q)
			S_PREP: begin
				mag_q <= mag_w;
				quo_q <= mag_w;
				rem_q <= '0;
				def_q <= '0;
			end
			S_DIVA, S_DIVB: begin
				rem_q <= ge ? NORM_W'(trial - {1'b0, norm_q}) : trial[NORM_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], ge};
			end
			S_SQ: begin
				qm_q <= quo_q;
				rm_q <= rem_q;
				sq_q <= SQ_W'(mag_q[SQ_IN_W-1:0]) * SQ_W'(mag_q[SQ_IN_W-1:0]);
			end
			S_LOADB: begin
				quo_q <= sq_q[SQ_W-1:FRAC_SHIFT];
				rem_q <= '0;
				def_q <= '1;
			end
			S_DEF: begin
				def_q <= (quo_q[DIV_W-1:DEF_W] != '0) ? '1 : quo_q[DEF_W-1:0];
			end
			S_CALC: begin
				prod_q <= PROD_W'(rd_coef) * PROD_W'(qm_q);
				frac_q <= small_div(SMALL_W'(rd_coef) * SMALL_W'(rm_q), norm_q);
			end
			default: begin
			end
		endcase
	end

	// species buffer: coefficient above concentration
	always_ff @(posedge clk) begin
		if (req && room) begin
			mem[count_q[ADDR_W-1:0]] <= {coefficient, concentration};
		end
		if (state_q == S_RD) begin
			rd_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT) begin
			if (ok_q) begin
				conc_out_q <= signed'(rd_q[CONC_BITS-1:0]);
			end else if (sum_sat) begin
				conc_out_q <= signed'({1'b0, {(CONC_BITS - 1){1'b1}}});
			end else begin
				conc_out_q <= sum[CONC_BITS-1:0];
			end
			deficit_q   <= def_q;
			fulfilled_q <= ok_q;
			eor_q       <= idx_last;
		end
	end

	assign strobe         = strobe_q;
	assign projected_conc = conc_out_q;
	assign deficit        = deficit_q;
	assign fulfilled      = fulfilled_q;
	assign end_of_run     = eor_q;

endmodule

`default_nettype wire
